[src/cdq_pkg.sv]
// Shared types and constants for the circular deque.
// No dependencies; every other file refers to this package by scoped names.
package cdq_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int VAL_W         = 32;
	localparam int CNT_W         = 7;
	localparam int CFG_W         = 7;
	localparam int CFG_IW        = 1;

	localparam logic [CFG_IW-1:0] CFG_CAPACITY = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_MODE     = 1'b1;

	localparam logic [CFG_W-1:0] CAPACITY_RESET = 7'd64;
	localparam logic             MODE_IN_RESTR  = 1'b0;
	localparam logic             MODE_OUT_RESTR = 1'b1;

	typedef enum logic [1:0] {
		OP_INS_REAR  = 2'd0,
		OP_INS_FRONT = 2'd1,
		OP_DEL_FRONT = 2'd2,
		OP_DEL_REAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_MODE  = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEEK,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [VAL_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] removed_value;
		stat_t                   status;
		logic [CNT_W-1:0]        entry_count;
	} out_word_t;

	// write request into the ring, applied at the cell that closes the loop
	typedef struct packed {
		logic             wr;
		logic [VAL_W-1:0] data;
	} ring_ctl_t;

endpackage

[src/cdq_cell.sv]
// One storage cell of the rotating ring: takes its neighbour's word each cycle
// or a new word when loaded. Depends on cdq_pkg.
module cdq_cell (
	input  logic                    clk,
	input  logic [cdq_pkg::VAL_W-1:0] shift_in,
	input  cdq_pkg::ring_ctl_t      ctl,
	output logic [cdq_pkg::VAL_W-1:0] q
);

	logic [cdq_pkg::VAL_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			data_q <= ctl.data;
		end else begin
			data_q <= shift_in;
		end
	end

	assign q = data_q;

endmodule

[src/cdq_ring.sv]
// Ring of DEPTH cells rotating by one each cycle, with the index of the entry
// now at the head cell. Depends on cdq_pkg and cdq_cell.
module cdq_ring #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cdq_pkg::ring_ctl_t           ctl,
	output logic [$clog2(DEPTH)-1:0]     head_idx,
	output logic [cdq_pkg::VAL_W-1:0]    head_data
);

	localparam int IW = $clog2(DEPTH);

	logic [cdq_pkg::VAL_W-1:0] cell_q [DEPTH];
	cdq_pkg::ring_ctl_t        cell_ctl [DEPTH];
	logic [IW-1:0]             rot_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_tail
			assign cell_ctl[i] = ctl;
		end else begin : g_body
			assign cell_ctl[i] = '0;
		end

		cdq_cell u_cell (
			.clk      (clk),
			.shift_in (cell_q[(i + 1) % DEPTH]),
			.ctl      (cell_ctl[i]),
			.q        (cell_q[i])
		);
	end

	// entry at the head moves to the tail cell; a write replaces it there
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
		end else if (rot_q == IW'(DEPTH - 1)) begin
			rot_q <= '0;
		end else begin
			rot_q <= rot_q + IW'(1);
		end
	end

	assign head_idx  = rot_q;
	assign head_data = cell_q[0];

endmodule

[src/cdq_ctrl.sv]
// Operation decode, front/rear pointers, count and result register.
// Depends on cdq_pkg; drives the write request of cdq_ring.
module cdq_ctrl #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  cdq_pkg::in_word_t          in_word,
	output logic                       out_valid,
	input  logic                       out_stall,
	output cdq_pkg::out_word_t         out_word,
	input  logic [cdq_pkg::CFG_W-1:0]  capacity,
	input  logic                       mode,
	input  logic [$clog2(DEPTH)-1:0]   head_idx,
	input  logic [cdq_pkg::VAL_W-1:0]  head_data,
	output cdq_pkg::ring_ctl_t         ring_ctl
);

	localparam int IW   = $clog2(DEPTH);
	localparam int EW   = $clog2(DEPTH + 1);
	localparam int CMPW = (EW > cdq_pkg::CFG_W) ? EW : cdq_pkg::CFG_W;
	localparam int CW   = cdq_pkg::CNT_W;

	cdq_pkg::state_t state_q, state_d;

	logic [IW-1:0] front_q, rear_q, front_d, rear_d, addr_d, addr_q;
	logic [CW-1:0] count_q, count_d;
	logic          access_d, write_d, wr_q;
	cdq_pkg::stat_t status_d, status_q;
	logic [cdq_pkg::VAL_W-1:0] wdata_q, rdata_q;
	logic          out_valid_q;
	cdq_pkg::out_word_t out_q;

	logic accept, hit, rd_hit, load_out;

	logic [CMPW-1:0] cap_x, eff, front_x, rear_x, cnt_x;
	logic [CMPW-1:0] f_up, f_dn, r_up, r_dn;

	// capacity of 0 acts as 1, above DEPTH as DEPTH
	always_comb begin
		cap_x = CMPW'(capacity);
		if (cap_x == '0) begin
			eff = CMPW'(1);
		end else if (cap_x > CMPW'(DEPTH)) begin
			eff = CMPW'(DEPTH);
		end else begin
			eff = cap_x;
		end
		front_x = CMPW'(front_q);
		rear_x  = CMPW'(rear_q);
		cnt_x   = CMPW'(count_q);
		f_up = (front_x + CMPW'(1) >= eff) ? '0 : front_x + CMPW'(1);
		r_up = (rear_x + CMPW'(1) >= eff) ? '0 : rear_x + CMPW'(1);
		f_dn = (front_x == '0 || front_x >= eff) ? eff - CMPW'(1) : front_x - CMPW'(1);
		r_dn = (rear_x == '0 || rear_x >= eff) ? eff - CMPW'(1) : rear_x - CMPW'(1);
	end

	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		count_d  = count_q;
		addr_d   = '0;
		access_d = 1'b0;
		write_d  = 1'b0;
		status_d = cdq_pkg::STAT_OK;
		if ((in_word.operation == cdq_pkg::OP_INS_FRONT && mode == cdq_pkg::MODE_IN_RESTR) ||
			(in_word.operation == cdq_pkg::OP_DEL_REAR && mode == cdq_pkg::MODE_OUT_RESTR)) begin
			status_d = cdq_pkg::STAT_MODE;
		end else if (in_word.operation == cdq_pkg::OP_INS_REAR ||
			in_word.operation == cdq_pkg::OP_INS_FRONT) begin
			if (cnt_x >= eff) begin
				status_d = cdq_pkg::STAT_FULL;
			end else begin
				access_d = 1'b1;
				write_d  = 1'b1;
				count_d  = count_q + CW'(1);
				if (in_word.operation == cdq_pkg::OP_INS_REAR) begin
					addr_d = rear_q;
					rear_d = IW'(r_up);
				end else begin
					addr_d  = IW'(f_dn);
					front_d = IW'(f_dn);
				end
			end
		end else begin
			if (count_q == '0) begin
				status_d = cdq_pkg::STAT_EMPTY;
			end else begin
				access_d = 1'b1;
				count_d  = count_q - CW'(1);
				if (in_word.operation == cdq_pkg::OP_DEL_FRONT) begin
					addr_d  = front_q;
					front_d = IW'(f_up);
				end else begin
					addr_d = IW'(r_dn);
					rear_d = IW'(r_dn);
				end
				if (count_q == CW'(1)) begin
					front_d = '0;
					rear_d  = '0;
				end
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		accept        = 1'b0;
		load_out      = 1'b0;
		hit           = (head_idx == addr_q);
		rd_hit        = 1'b0;
		ring_ctl.wr   = 1'b0;
		ring_ctl.data = wdata_q;
		case (state_q)
			cdq_pkg::S_IDLE: begin
				if (in_valid) begin
					accept  = 1'b1;
					state_d = access_d ? cdq_pkg::S_SEEK : cdq_pkg::S_DONE;
				end
			end
			cdq_pkg::S_SEEK: begin
				if (hit) begin
					ring_ctl.wr = wr_q;
					rd_hit      = !wr_q;
					state_d     = cdq_pkg::S_DONE;
				end
			end
			cdq_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = cdq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cdq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdq_pkg::S_IDLE;
			front_q     <= '0;
			rear_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				front_q <= front_d;
				rear_q  <= rear_d;
				count_q <= count_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= addr_d;
			wr_q     <= write_d;
			wdata_q  <= in_word.value;
			status_q <= status_d;
			rdata_q  <= '0;
		end
		if (rd_hit) begin
			rdata_q <= head_data;
		end
		if (load_out) begin
			out_q.removed_value <= rdata_q;
			out_q.status        <= status_q;
			out_q.entry_count   <= count_q;
		end
	end

	assign in_stall  = (state_q != cdq_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

[src/circular_deque.sv]
// Top level of the circular deque: configuration registers, controller and
// rotating cell ring. Depends on cdq_pkg, cdq_ctrl, cdq_ring, cdq_cell.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------
//   in       | in_valid / in_stall   | in_word  (operation, value)
//   out      | out_valid / out_stall | out_word (removed_value, status, entry_count)
//   config   | cfg_we                | cfg_index, cfg_data
//
// An item that touches the store waits in the seek state for its entry to
// rotate to the head cell; a rejected operation (full, empty, mode) goes
// straight to the done state. Reset empties the deque, sets capacity to 64
// and input-restricted mode; the store is not cleared. The input is stalled
// until an item is done. A stalled result is held in the output register;
// the next word is still taken and processed, then waits in the done state,
// with the input stalled, until the held result is taken.
module circular_deque #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  cdq_pkg::in_word_t           in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output cdq_pkg::out_word_t          out_word,
	input  logic                        cfg_we,
	input  logic [cdq_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [cdq_pkg::CFG_W-1:0]   cfg_data
);

	logic [cdq_pkg::CFG_W-1:0]  capacity_q;
	logic                       mode_q;
	logic [$clog2(DEPTH)-1:0]   head_idx;
	logic [cdq_pkg::VAL_W-1:0]  head_data;
	cdq_pkg::ring_ctl_t         ring_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= cdq_pkg::CAPACITY_RESET;
			mode_q     <= cdq_pkg::MODE_IN_RESTR;
		end else if (cfg_we) begin
			case (cfg_index)
				cdq_pkg::CFG_CAPACITY: capacity_q <= cfg_data;
				cdq_pkg::CFG_MODE:     mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cdq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.capacity  (capacity_q),
		.mode      (mode_q),
		.head_idx  (head_idx),
		.head_data (head_data),
		.ring_ctl  (ring_ctl)
	);

	cdq_ring #(
		.DEPTH (DEPTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ring_ctl),
		.head_idx  (head_idx),
		.head_data (head_data)
	);

endmodule
